[design/ppl_pkg.sv]
// Package: shared widths, limits and a helper function of the parameter list parser.
`default_nettype none
package ppl_pkg;

  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 3;
  localparam int PNUM_W   = 6;
  localparam int STATUS_W = 4;
  localparam int IDENT_W  = 30;

  localparam int IDENT_MAX_DIGITS = 9;

  // Parameter index saturates at this count.
  localparam int MAX_PARAMS = 63;
  localparam int PARAM_CAP  = (MAX_PARAMS > 63) ? 63 : MAX_PARAMS;

  // Bits needed to hold any value of the given number of decimal digits.
  function automatic int run_width(input int digits);
    logic [64:0] p;
    p = 65'd1;
    for (int i = 0; i < digits; i++) begin
      p = p * 65'd10;
    end
    return $clog2(p);
  endfunction

endpackage
`default_nettype wire

[design/ppl_in_if.sv]
// Interface: input item channel (one character and its end marker).
`default_nettype none
interface ppl_in_if;
  logic                        valid;
  logic                        ready;
  logic [ppl_pkg::BYTE_W-1:0]  data_byte;
  logic                        last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface
`default_nettype wire

[design/ppl_out_if.sv]
// Interface: result item channel (classified character and running status).
`default_nettype none
interface ppl_out_if;
  logic                          valid;
  logic                          ready;
  logic [ppl_pkg::BYTE_W-1:0]    out_byte;
  logic [ppl_pkg::KIND_W-1:0]    byte_kind;
  logic [ppl_pkg::PNUM_W-1:0]    param_number;
  logic                          done_res;
  logic [ppl_pkg::STATUS_W-1:0]  status;
  logic [ppl_pkg::IDENT_W-1:0]   ident_value;
  logic                          ident_found;

  modport source (output valid, out_byte, byte_kind, param_number, done_res, status,
                  ident_value, ident_found, input ready);
  modport sink   (input valid, out_byte, byte_kind, param_number, done_res, status,
                  ident_value, ident_found, output ready);
endinterface
`default_nettype wire

[design/packet_param_list_parser.sv]
// Top level: streaming checker for a comma-separated parameter list.
`default_nettype none
// Takes one character per cycle and returns one result item per character
// through the input register, then the result register. A new item is
// accepted every cycle while the result side keeps up; the next parser
// state (phase, digit run, sticky error) is combinational, with the
// times-ten digit accumulate plus zero test as the longest path. The item
// marked last carries the final status and ident and clears the state for
// the next string. The user must write require_ident through cfg_we/cfg_wdata
// only while the block is idle; the block does not enforce it. It resets to 1.
module packet_param_list_parser #(
  parameter int IDENT_MAX_DIGITS = ppl_pkg::IDENT_MAX_DIGITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ppl_in_if.sink     in_if,
  ppl_out_if.source  out_if,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata
);

  localparam int RUN_W   = ppl_pkg::run_width(IDENT_MAX_DIGITS);
  localparam int CNT_MAX = IDENT_MAX_DIGITS + 1;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int BW      = ppl_pkg::BYTE_W;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_IDENT = 2'd1;
  localparam logic [1:0] PH_KEY   = 2'd2;
  localparam logic [1:0] PH_VALUE = 2'd3;

  localparam logic [2:0] KIND_DIGIT   = 3'd0;
  localparam logic [2:0] KIND_KEY     = 3'd1;
  localparam logic [2:0] KIND_EQUALS  = 3'd2;
  localparam logic [2:0] KIND_VALUE   = 3'd3;
  localparam logic [2:0] KIND_COMMA   = 3'd4;
  localparam logic [2:0] KIND_IGNORED = 3'd5;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_EMPTY     = 4'd1;
  localparam logic [3:0] ST_BAD_START = 4'd2;
  localparam logic [3:0] ST_ZERO_ID   = 4'd3;
  localparam logic [3:0] ST_ID_NONDIG = 4'd4;
  localparam logic [3:0] ST_LEAD_ZERO = 4'd5;
  localparam logic [3:0] ST_KEY_CHAR  = 4'd6;
  localparam logic [3:0] ST_VAL_CHAR  = 4'd7;
  localparam logic [3:0] ST_NO_IDENT  = 4'd8;

  localparam logic [BW-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BW-1:0] CH_EQUALS = 8'h3D;
  localparam logic [BW-1:0] CH_SPACE  = 8'h20;
  localparam logic [BW-1:0] CH_COLON  = 8'h3A;
  localparam logic [BW-1:0] CH_LT     = 8'h3C;
  localparam logic [BW-1:0] CH_NUL    = 8'h00;
  localparam logic [BW-1:0] CH_0      = 8'h30;
  localparam logic [BW-1:0] CH_9      = 8'h39;
  localparam logic [BW-1:0] CH_LA     = 8'h61;
  localparam logic [BW-1:0] CH_LZ     = 8'h7A;
  localparam logic [BW-1:0] CH_UA     = 8'h41;
  localparam logic [BW-1:0] CH_UZ     = 8'h5A;

  localparam logic [ppl_pkg::PNUM_W-1:0] PCAP = ppl_pkg::PNUM_W'(ppl_pkg::PARAM_CAP);
  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(IDENT_MAX_DIGITS);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(CNT_MAX);

  // input stage
  logic          s1_v_r;
  logic [BW-1:0] s1_byte_r;
  logic          s1_last_r;
  logic          adv;

  // parser state
  logic                        req_ident_r;
  logic [1:0]                  phase_r, phase_nxt;
  logic [RUN_W-1:0]            run_r, run_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        fzero_r, fzero_nxt;
  logic                        nondig_r, nondig_nxt;
  logic [ppl_pkg::IDENT_W-1:0] kept_r, kept_nxt;
  logic                        seen_r, seen_nxt;
  logic [3:0]                  err_r, err_nxt;
  logic [ppl_pkg::PNUM_W-1:0]  pidx_r, pidx_nxt;

  // result register
  logic                        out_v_r;
  logic [BW-1:0]               out_byte_r;
  logic [2:0]                  out_kind_r, kind_nxt;
  logic [ppl_pkg::PNUM_W-1:0]  out_pnum_r;
  logic                        out_done_r;
  logic [3:0]                  out_status_r, status_nxt;
  logic [ppl_pkg::IDENT_W-1:0] out_ident_r;
  logic                        out_found_r;

  logic          c_digit, c_letter, c_badval;
  logic          do_add, do_end, do_next;
  logic [BW-1:0] c;

  assign adv         = s1_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !s1_v_r || adv;

  assign c        = s1_byte_r;
  assign c_digit  = (c >= CH_0) && (c <= CH_9);
  assign c_letter = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
  assign c_badval = (c == CH_EQUALS) || (c == CH_SPACE) || (c == CH_COMMA) ||
                    (c == CH_COLON) || (c == CH_LT) || (c == CH_NUL);

  always_comb begin
    phase_nxt  = phase_r;
    run_nxt    = run_r;
    cnt_nxt    = cnt_r;
    fzero_nxt  = fzero_r;
    nondig_nxt = nondig_r;
    kept_nxt   = kept_r;
    seen_nxt   = seen_r;
    err_nxt    = err_r;
    pidx_nxt   = pidx_r;
    kind_nxt   = KIND_IGNORED;
    do_add     = 1'b0;
    do_end     = 1'b0;
    do_next    = 1'b0;

    if (err_r == ST_OK) begin
      case (phase_r)
        PH_START: begin
          if (c == CH_COMMA) begin
            err_nxt = ST_EMPTY;
          end else if (c_digit) begin
            phase_nxt = PH_IDENT;
            fzero_nxt = (c == CH_0);
            do_add    = 1'b1;
            kind_nxt  = KIND_DIGIT;
          end else if (c_letter) begin
            phase_nxt = PH_KEY;
            kind_nxt  = KIND_KEY;
          end else begin
            err_nxt = ST_BAD_START;
          end
        end
        PH_IDENT: begin
          if (c == CH_COMMA) begin
            do_end   = 1'b1;
            do_next  = 1'b1;
            kind_nxt = KIND_COMMA;
          end else begin
            do_add   = 1'b1;
            kind_nxt = KIND_DIGIT;
          end
        end
        PH_KEY: begin
          if (c == CH_COMMA) begin
            do_next  = 1'b1;
            kind_nxt = KIND_COMMA;
          end else if (c == CH_EQUALS) begin
            phase_nxt = PH_VALUE;
            kind_nxt  = KIND_EQUALS;
          end else if (c_letter || c_digit) begin
            kind_nxt = KIND_KEY;
          end else begin
            err_nxt = ST_KEY_CHAR;
          end
        end
        default: begin
          if (c == CH_COMMA) begin
            do_next  = 1'b1;
            kind_nxt = KIND_COMMA;
          end else if (c_badval) begin
            err_nxt = ST_VAL_CHAR;
          end else begin
            kind_nxt = KIND_VALUE;
          end
        end
      endcase

      if (do_add && !nondig_r) begin
        if (!c_digit) begin
          nondig_nxt = 1'b1;
        end else begin
          if (cnt_r < CNT_LIM) begin
            run_nxt = (run_r << 3) + (run_r << 1) + RUN_W'(c[3:0]);
          end else if ((c != CH_0) && (run_r == '0)) begin
            run_nxt = RUN_W'(1);
          end
          if (cnt_r < CNT_TOP) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end

      if (s1_last_r && (err_nxt == ST_OK) && (phase_nxt == PH_IDENT)) begin
        do_end = 1'b1;
      end

      if (do_end) begin
        if (run_nxt == '0) begin
          err_nxt = ST_ZERO_ID;
        end else if (nondig_nxt) begin
          err_nxt = ST_ID_NONDIG;
        end else if (fzero_nxt || (cnt_nxt > CNT_LIM)) begin
          err_nxt = ST_LEAD_ZERO;
        end else begin
          kept_nxt = ppl_pkg::IDENT_W'(run_nxt);
          seen_nxt = 1'b1;
        end
      end

      if (do_next && (err_nxt == ST_OK)) begin
        phase_nxt  = PH_START;
        run_nxt    = '0;
        cnt_nxt    = '0;
        fzero_nxt  = 1'b0;
        nondig_nxt = 1'b0;
        if (pidx_r < PCAP) begin
          pidx_nxt = pidx_r + ppl_pkg::PNUM_W'(1);
        end
      end

      if (err_nxt != ST_OK) begin
        kind_nxt = KIND_IGNORED;
      end
    end

    status_nxt = err_nxt;
    if (s1_last_r && (err_nxt == ST_OK) && req_ident_r && !seen_nxt) begin
      status_nxt = ST_NO_IDENT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      req_ident_r <= 1'b1;
      phase_r     <= PH_START;
      run_r       <= '0;
      cnt_r       <= '0;
      fzero_r     <= 1'b0;
      nondig_r    <= 1'b0;
      kept_r      <= '0;
      seen_r      <= 1'b0;
      err_r       <= ST_OK;
      pidx_r      <= '0;
    end else begin
      if (cfg_we) begin
        req_ident_r <= cfg_wdata;
      end
      if (in_if.ready) begin
        s1_v_r <= in_if.valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
      if (adv) begin
        if (s1_last_r) begin
          phase_r  <= PH_START;
          run_r    <= '0;
          cnt_r    <= '0;
          fzero_r  <= 1'b0;
          nondig_r <= 1'b0;
          kept_r   <= '0;
          seen_r   <= 1'b0;
          err_r    <= ST_OK;
          pidx_r   <= '0;
        end else begin
          phase_r  <= phase_nxt;
          run_r    <= run_nxt;
          cnt_r    <= cnt_nxt;
          fzero_r  <= fzero_nxt;
          nondig_r <= nondig_nxt;
          kept_r   <= kept_nxt;
          seen_r   <= seen_nxt;
          err_r    <= err_nxt;
          pidx_r   <= pidx_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_byte_r <= in_if.data_byte;
      s1_last_r <= in_if.last_byte;
    end
    if (adv) begin
      out_byte_r   <= s1_byte_r;
      out_kind_r   <= kind_nxt;
      out_pnum_r   <= pidx_r;
      out_done_r   <= s1_last_r;
      out_status_r <= status_nxt;
      out_ident_r  <= kept_nxt;
      out_found_r  <= seen_nxt;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.out_byte     = out_byte_r;
  assign out_if.byte_kind    = out_kind_r;
  assign out_if.param_number = out_pnum_r;
  assign out_if.done_res     = out_done_r;
  assign out_if.status       = out_status_r;
  assign out_if.ident_value  = out_ident_r;
  assign out_if.ident_found  = out_found_r;

`ifndef ASSERT_OFF
  a_no_ident_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_done_r) |-> (out_status_r != ST_NO_IDENT))
    else $error("no-ident status on an item that is not last");

  a_error_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_status_r != ST_OK) && (out_status_r != ST_NO_IDENT))
      |-> (out_kind_r == KIND_IGNORED))
    else $error("item under error not marked ignored");

  a_cleared_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_last_r) |=> ((err_r == ST_OK) && (pidx_r == '0) && !seen_r &&
                            (phase_r == PH_START)))
    else $error("state not cleared after last item");

  a_ident_zero_unfound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_found_r) |-> (out_ident_r == '0))
    else $error("ident value without accepted ident");
`endif

endmodule
`default_nettype wire
